// ===== rtl/wind_magnitude_flux_unit_assert.svh =====
// Assertion macros for the wind magnitude and flux unit.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef WIND_MAGNITUDE_FLUX_UNIT_ASSERT_SVH
`define WIND_MAGNITUDE_FLUX_UNIT_ASSERT_SVH

// same-cycle implication
`define WMF_ASSERT_NOW(LBL, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANTE) |-> (CONS)) \
        else $error(MSG);

// next-cycle implication
`define WMF_ASSERT_NEXT(LBL, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// ===== rtl/wmf_pkg.sv =====
// Shared constants for the wind magnitude and flux unit.
// No dependencies.
`timescale 1ns / 1ps

package wmf_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int OUT_WIDTH        = 48;
    localparam int FRAC_SHIFT       = 16;

    localparam logic MODE_SPEED      = 1'b0;
    localparam logic MODE_FLUX       = 1'b1;
    localparam logic FLUX_MODE_RESET = MODE_FLUX;

    localparam logic [OUT_WIDTH-1:0] OUT_MAX_POS = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] OUT_MAX_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};

endpackage

// ===== rtl/wmf_sample_if.sv =====
// Input item channel: two wind components and two scalar fields.
// Depends on wmf_pkg.
`timescale 1ns / 1ps

interface wmf_sample_if #(
    parameter int SAMPLE_WIDTH = wmf_pkg::SAMPLE_WIDTH_DEF
);
    import wmf_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] u_wind;
    logic signed [SAMPLE_WIDTH-1:0] v_wind;
    logic signed [SAMPLE_WIDTH-1:0] scalar_a;
    logic signed [SAMPLE_WIDTH-1:0] scalar_b;

    modport source (output valid, u_wind, v_wind, scalar_a, scalar_b, input ready);
    modport sink   (input valid, u_wind, v_wind, scalar_a, scalar_b, output ready);
endinterface

// ===== rtl/wmf_result_if.sv =====
// Result item channel: speed or flux value and saturation flag.
// Depends on wmf_pkg.
`timescale 1ns / 1ps

interface wmf_result_if;
    import wmf_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] flux_value;
    logic                        saturated;

    modport source (output valid, flux_value, saturated, input ready);
    modport sink   (input valid, flux_value, saturated, output ready);
endinterface

// ===== rtl/wmf_cfg_if.sv =====
// Configuration write channel carrying the flux_mode register.
// Depends on wmf_pkg.
`timescale 1ns / 1ps

interface wmf_cfg_if;
    import wmf_pkg::*;

    logic valid;
    logic ready;
    logic flux_mode;

    modport source (output valid, flux_mode, input ready);
    modport sink   (input valid, flux_mode, output ready);
endinterface

// ===== rtl/wind_magnitude_flux_unit.sv =====
// Wind magnitude and flux unit: pipelined floor sqrt of u^2+v^2, optional flux product.
// Depends on wmf_pkg, wmf_sample_if, wmf_result_if, wmf_cfg_if and the assertion header.
`timescale 1ns / 1ps
`include "wind_magnitude_flux_unit_assert.svh"

// Usage
//   sample : one grid point per item (u_wind, v_wind, scalar_a, scalar_b, signed Q.8).
//   result : one item per sample (flux_value signed Q.8 saturated, saturated flag).
//   cfg    : writes flux_mode (0 = speed, 1 = speed * scalar_a * scalar_b >> 16);
//            always ready, write only while no item is in flight.
//   Pipeline of SAMPLE_WIDTH + 7 register stages: magnitudes, squares, sum,
//   one stage per root bit (SAMPLE_WIDTH), speed*scalar_a, two partial
//   products by scalar_b, their sum, then rounding/saturation into the
//   output register.
//   Throughput: one item per cycle unless the receiver stalls a full pipeline.
//   Receiver stall: stages hold their items; empty stages still fill, and
//   sample.ready drops only when every stage holds an item.
//   Reset: all stages empty, flux_mode = 1.

module wind_magnitude_flux_unit #(
    parameter int SAMPLE_WIDTH = wmf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    wmf_sample_if.sink   sample,
    wmf_result_if.source result,
    wmf_cfg_if.sink      cfg
);
    import wmf_pkg::*;

    localparam int W       = SAMPLE_WIDTH;
    localparam int RW      = 2 * W;
    localparam int TW      = 3 * W;
    localparam int XW      = (TW > OUT_WIDTH + FRAC_SHIFT) ? TW : OUT_WIDTH + FRAC_SHIFT;
    localparam int SAT_BIT = OUT_WIDTH + FRAC_SHIFT - 1;
    localparam int SQ0     = 3;
    localparam int P1      = SQ0 + W;
    localparam int P2      = P1 + 1;
    localparam int P3      = P2 + 1;
    localparam int OST     = P3 + 1;
    localparam int NSTG    = OST + 1;

    typedef struct packed {
        logic [W-1:0] a_mag;
        logic [W-1:0] b_mag;
        logic         neg;
    } side_t;

    function automatic logic [W-1:0] abs_mag(input logic [W-1:0] x);
        abs_mag = x[W-1] ? (~x + W'(1)) : x;
    endfunction

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] rdy;
    logic            flux_mode_reg;

    logic [W-1:0]    umag_reg, vmag_reg;
    logic [RW-1:0]   uu_reg, vv_reg;
    side_t           side_reg [0:SQ0+W-1];
    logic [RW-1:0]   rem_reg  [0:W];
    logic [W-1:0]    root_reg [1:W];

    logic [RW-1:0]   p1_reg;
    logic [W-1:0]    p1_b_reg, p1_root_reg;
    logic            p1_neg_reg;
    logic [RW-1:0]   lo_reg, hi_reg;
    logic [W-1:0]    p2_root_reg;
    logic            p2_neg_reg;
    logic [TW-1:0]   t_reg;
    logic [W-1:0]    p3_root_reg;
    logic            p3_neg_reg;
    logic [OUT_WIDTH-1:0] flux_value_reg;
    logic            saturated_reg;

    // ---- handshake ----
    for (genvar k = 0; k < NSTG; k++) begin : g_rdy
        assign rdy[k] = result.ready | ~(&v_reg[NSTG-1:k]);
    end

    assign sample.ready      = rdy[0];
    assign result.valid      = v_reg[NSTG-1];
    assign result.flux_value = flux_value_reg;
    assign result.saturated  = saturated_reg;
    assign cfg.ready         = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= sample.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flux_mode_reg <= FLUX_MODE_RESET;
        end
        else if (cfg.valid)
        begin
            flux_mode_reg <= cfg.flux_mode;
        end
    end

    // ---- magnitudes, squares, sum ----
    side_t side_next;

    always_comb
    begin
        side_next.a_mag = abs_mag(sample.scalar_a);
        side_next.b_mag = abs_mag(sample.scalar_b);
        side_next.neg   = sample.scalar_a[W-1] ^ sample.scalar_b[W-1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            umag_reg    <= abs_mag(sample.u_wind);
            vmag_reg    <= abs_mag(sample.v_wind);
            side_reg[0] <= side_next;
        end
        if (rdy[1])
        begin
            uu_reg      <= RW'(umag_reg) * RW'(umag_reg);
            vv_reg      <= RW'(vmag_reg) * RW'(vmag_reg);
            side_reg[1] <= side_reg[0];
        end
        if (rdy[2])
        begin
            rem_reg[0]  <= uu_reg + vv_reg;
            side_reg[2] <= side_reg[1];
        end
    end

    // ---- square root, one result bit per stage ----
    for (genvar s = 0; s < W; s++) begin : g_sqrt
        localparam int J = W - 1 - s;
        logic [W-1:0]  r_prev;
        logic [RW-1:0] trial;
        logic          take;
        logic [RW-1:0] rem_next;
        logic [W-1:0]  root_next;

        if (s == 0) begin : g_first
            assign r_prev = '0;
        end
        else begin : g_rest
            assign r_prev = root_reg[s];
        end

        // (2r + 2^J) * 2^J with r holding only bits above J
        assign trial     = (RW'(r_prev) << (J + 1)) | (RW'(1) << (2 * J));
        assign take      = (rem_reg[s] >= trial);
        assign rem_next  = take ? (rem_reg[s] - trial) : rem_reg[s];
        assign root_next = take ? (r_prev | (W'(1) << J)) : r_prev;

        always_ff @(posedge clk)
        begin
            if (rdy[SQ0+s])
            begin
                rem_reg[s+1]      <= rem_next;
                root_reg[s+1]     <= root_next;
                side_reg[SQ0+s]   <= side_reg[SQ0+s-1];
            end
        end
    end

    // ---- flux products ----
    logic [TW-1:0] t_next;

    assign t_next = {hi_reg, {W{1'b0}}} + TW'(lo_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[P1])
        begin
            p1_reg      <= RW'(root_reg[W]) * RW'(side_reg[P1-1].a_mag);
            p1_b_reg    <= side_reg[P1-1].b_mag;
            p1_neg_reg  <= side_reg[P1-1].neg;
            p1_root_reg <= root_reg[W];
        end
        if (rdy[P2])
        begin
            lo_reg      <= RW'(p1_reg[W-1:0]) * RW'(p1_b_reg);
            hi_reg      <= RW'(p1_reg[RW-1:W]) * RW'(p1_b_reg);
            p2_neg_reg  <= p1_neg_reg;
            p2_root_reg <= p1_root_reg;
        end
        if (rdy[P3])
        begin
            t_reg       <= t_next;
            p3_neg_reg  <= p2_neg_reg;
            p3_root_reg <= p2_root_reg;
        end
    end

    // ---- rescale, round toward minus infinity, saturate ----
    logic [XW-1:0]        t_ext;
    logic                 over;
    logic                 exact_min;
    logic                 frac_nz;
    logic [OUT_WIDTH-1:0] mid;
    logic [OUT_WIDTH-1:0] flux_value_next;
    logic                 saturated_next;

    always_comb
    begin
        t_ext     = XW'(t_reg);
        over      = |t_ext[XW-1:SAT_BIT];
        exact_min = (t_ext[XW-1:SAT_BIT] == (XW-SAT_BIT)'(1)) && (t_ext[SAT_BIT-1:0] == '0);
        frac_nz   = |t_ext[FRAC_SHIFT-1:0];
        mid       = t_ext[SAT_BIT:FRAC_SHIFT];
        if (flux_mode_reg == MODE_SPEED)
        begin
            flux_value_next = OUT_WIDTH'(p3_root_reg);
            saturated_next  = 1'b0;
        end
        else if (!p3_neg_reg)
        begin
            saturated_next  = over;
            flux_value_next = over ? OUT_MAX_POS : {1'b0, t_ext[SAT_BIT-1:FRAC_SHIFT]};
        end
        else
        begin
            // -(mid + frac_nz) == ~mid + !frac_nz
            saturated_next  = over && !exact_min;
            flux_value_next = saturated_next ? OUT_MAX_NEG
                                             : (~mid + OUT_WIDTH'(!frac_nz));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[OST])
        begin
            flux_value_reg <= flux_value_next;
            saturated_reg  <= saturated_next;
        end
    end

    // ---- assertions ----
    `WMF_ASSERT_NOW(a_speed_no_sat, result.valid && flux_mode_reg == MODE_SPEED,
        !result.saturated, "speed result flagged as saturated")
    `WMF_ASSERT_NOW(a_sat_extreme, result.valid && result.saturated,
        result.flux_value == OUT_MAX_POS || result.flux_value == OUT_MAX_NEG,
        "saturated result is not at a range limit")
    `WMF_ASSERT_NOW(a_full_when_blocked, !sample.ready, &v_reg,
        "input blocked while a pipeline stage is empty")
    `WMF_ASSERT_NOW(a_sqrt_rem, v_reg[P1-1],
        rem_reg[W] <= RW'({root_reg[W], 1'b0}),
        "square root remainder out of range")
    `WMF_ASSERT_NEXT(a_hold_on_stall, result.valid && !result.ready,
        result.valid && &v_reg[NSTG-1:NSTG-1] && $stable(flux_value_reg),
        "stalled result register changed")

endmodule
